/* rtl/rbbm_pkg.sv */
// ----------------------------------------------------------------------------
// rbbm_pkg: shared definitions for the receive byte buffer
// Sizes, operation codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbbm_pkg;

	localparam int BUFFER_BYTES = 1024;
	localparam int MAX_PATTERN  = 8;
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int OP_W         = 3;
	localparam int COUNT_W      = 11;
	localparam int PLEN_W       = 4;
	localparam int PAT_W        = 8 * MAX_PATTERN;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_DISCARD = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_BYTES - 1);

	typedef struct packed {
		logic take;
		logic load_now;
		logic srch_step;
		logic load_late;
	} rbbm_cmd_t;

	typedef struct packed {
		logic srch_done;
	} rbbm_stat_t;

	function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
		input logic [ADDR_W-1:0] offset);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, offset};
		if (sum >= (ADDR_W+1)'(BUFFER_BYTES)) begin
			sum = sum - (ADDR_W+1)'(BUFFER_BYTES);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/rbbm_ctrl.sv */
// ----------------------------------------------------------------------------
// rbbm_ctrl: controller of the receive byte buffer
// Sequences one transaction at a time, runs the search walk and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module rbbm_ctrl
	import rbbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   operation,
	output logic              out_valid,
	input  logic              out_stall,
	output rbbm_cmd_t         cmd,
	input  rbbm_stat_t        stat
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SRCH   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;

	always_comb begin
		state_d       = state_q;
		cmd.take      = 1'b0;
		cmd.load_now  = 1'b0;
		cmd.srch_step = 1'b0;
		cmd.load_late = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && out_free) begin
					cmd.take = 1'b1;
					if (operation == OP_SEARCH) begin
						state_d = ST_SRCH;
					end else if (operation == OP_READ) begin
						state_d = ST_FINISH;
					end else begin
						cmd.load_now = 1'b1;
					end
				end
			end
			ST_SRCH: begin
				cmd.srch_step = 1'b1;
				if (stat.srch_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_late = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_now || cmd.load_late) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/rbbm_dp.sv */
// ----------------------------------------------------------------------------
// rbbm_dp: datapath of the receive byte buffer
// Holds the byte store, the head and fill registers, the search window
// and the result registers.
// ----------------------------------------------------------------------------
module rbbm_dp
	import rbbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbbm_cmd_t            cmd,
	output rbbm_stat_t           stat,
	input  logic [OP_W-1:0]      operation,
	input  logic [7:0]           rx_byte,
	input  logic [COUNT_W-1:0]   discard_count,
	input  logic [PAT_W-1:0]     pattern_bytes,
	input  logic [PLEN_W-1:0]    pattern_length,
	input  logic [ADDR_W-1:0]    position,
	output logic                 found,
	output logic [7:0]           read_data,
	output logic                 read_valid,
	output logic [ADDR_W-1:0]    fill_level,
	output logic                 dropped
);

	logic [7:0]        mem [BUFFER_BYTES];
	logic [ADDR_W-1:0] fill_q;
	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] fill_d;
	logic [ADDR_W-1:0] head_d;
	logic              drop_d;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data_s1;
	logic              pend_s1;
	logic [OP_W-1:0]   op_q;
	logic              rvalid_q;
	logic [7:0]        pat_q [MAX_PATTERN];
	logic [7:0]        win_q [MAX_PATTERN];
	logic [PLEN_W-1:0] len_q;
	logic [PLEN_W-1:0] len_sat;
	logic [PLEN_W-1:0] cnt_q;
	logic [ADDR_W-1:0] idx_q;
	logic              match_q;
	logic              hit;
	logic              more;

	assign len_sat = (pattern_length > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN)
		: pattern_length;
	assign more    = idx_q != fill_q;

	always_comb begin
		fill_d = fill_q;
		head_d = head_q;
		drop_d = 1'b0;
		wr_en  = 1'b0;
		case (operation)
			OP_APPEND: begin
				if (fill_q < FILL_MAX) begin
					wr_en  = 1'b1;
					fill_d = fill_q + ADDR_W'(1);
				end else begin
					drop_d = 1'b1;
				end
			end
			OP_DISCARD: begin
				if (discard_count >= COUNT_W'(fill_q)) begin
					fill_d = '0;
					head_d = '0;
				end else if (discard_count != '0) begin
					head_d = slot_of(head_q, discard_count[ADDR_W-1:0]);
					fill_d = fill_q - discard_count[ADDR_W-1:0];
				end
			end
			OP_CLEAR: begin
				fill_d = '0;
				head_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = slot_of(head_q, fill_q);
	assign rd_en   = (cmd.take && (operation == OP_READ)) || (cmd.srch_step && more);
	assign rd_addr = cmd.take ? slot_of(head_q, position) : slot_of(head_q, idx_q);

	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) begin
			mem[wr_addr] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_comb begin
		hit = (len_q != '0) && (cnt_q >= len_q);
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if ((PLEN_W'(k) < len_q) && (win_q[k] != pat_q[k])) begin
				hit = 1'b0;
			end
		end
	end

	assign stat.srch_done = match_q || (!more && !pend_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			head_q  <= '0;
			pend_s1 <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			match_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				fill_q  <= fill_d;
				head_q  <= head_d;
				pend_s1 <= 1'b0;
				idx_q   <= '0;
				cnt_q   <= '0;
				match_q <= (len_sat == '0);
			end else if (cmd.srch_step) begin
				pend_s1 <= more;
				if (more) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (pend_s1 && (cnt_q < PLEN_W'(MAX_PATTERN))) begin
					cnt_q <= cnt_q + PLEN_W'(1);
				end
				match_q <= match_q || hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q     <= operation;
			rvalid_q <= position < fill_q;
			len_q    <= len_sat;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				pat_q[k] <= pattern_bytes[8*k +: 8];
			end
		end
		if (cmd.srch_step && pend_s1) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (PLEN_W'(j) == (len_q - PLEN_W'(1))) begin
					win_q[j] <= rd_data_s1;
				end else if (j < MAX_PATTERN - 1) begin
					win_q[j] <= win_q[(j + 1) % MAX_PATTERN];
				end
			end
		end
		if (cmd.load_now) begin
			found      <= 1'b0;
			read_data  <= '0;
			read_valid <= 1'b0;
			fill_level <= fill_d;
			dropped    <= drop_d;
		end else if (cmd.load_late) begin
			found      <= (op_q == OP_SEARCH) && match_q;
			read_valid <= (op_q == OP_READ) && rvalid_q;
			read_data  <= ((op_q == OP_READ) && rvalid_q) ? rd_data_s1 : '0;
			fill_level <= fill_q;
			dropped    <= 1'b0;
		end
	end

endmodule

/* rtl/rx_byte_buffer_with_match_top.sv */
// ----------------------------------------------------------------------------
// rx_byte_buffer_with_match_top: receive byte buffer with pattern search
// Holds up to 1023 received bytes and serves append, discard, clear,
// search and read requests, one result per request.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the input channel (in_valid, in_stall)
// carries the operation and its operands; exactly one result transaction
// follows on the output channel (out_valid, out_stall).
// Results: append, discard, clear and unused codes give their result in the
// cycle after acceptance; a read result passes through the registered read
// port of the byte store and then the output register. A search walks the
// held bytes through that single read port, one byte per cycle, and stops
// early at the first match.
// Throughput: one transaction is in progress at a time, so the next request
// is accepted once the previous one has finished and the output register
// is free or being emptied.
// Reset: the buffer is empty and the head returns to zero; the byte store
// itself is not cleared and needs no sweep.
// Stall: while the receiver stalls, the result holds on the outputs and no
// further request that would overwrite it is accepted.
// ----------------------------------------------------------------------------
module rx_byte_buffer_with_match_top
	import rbbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [7:0]           rx_byte,
	input  logic [COUNT_W-1:0]   discard_count,
	input  logic [PAT_W-1:0]     pattern_bytes,
	input  logic [PLEN_W-1:0]    pattern_length,
	input  logic [ADDR_W-1:0]    position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [7:0]           read_data,
	output logic                 read_valid,
	output logic [ADDR_W-1:0]    fill_level,
	output logic                 dropped
);

	rbbm_cmd_t  cmd;
	rbbm_stat_t stat;

	rbbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	rbbm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (operation),
		.rx_byte        (rx_byte),
		.discard_count  (discard_count),
		.pattern_bytes  (pattern_bytes),
		.pattern_length (pattern_length),
		.position       (position),
		.found          (found),
		.read_data      (read_data),
		.read_valid     (read_valid),
		.fill_level     (fill_level),
		.dropped        (dropped)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_level <= FILL_MAX))
		else $error("Reported fill exceeds the buffer capacity.");

	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (operation != OP_SEARCH) && (operation != OP_READ))
		|=> out_valid)
		else $error("Short operation did not produce its result in one cycle.");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_valid) |-> (!found && !dropped))
		else $error("Result carries fields of more than one operation.");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (operation == OP_SEARCH)) |=> in_stall)
		else $error("Request accepted while a search was in progress.");

endmodule
